[design/asc_pkg.sv]
package asc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 25;
    localparam int OFFSET_W = 22;
    localparam int STRIDE_W = 16;
    localparam int CHAN_W   = 4;
    localparam int X_W      = 25;
    localparam int CV_W     = 15;
    localparam int PROD_W   = GAIN_W + SAMPLE_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int FRAC_W   = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 25;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);
    localparam logic signed [SUM_W-1:0] X_LIMIT    = SUM_W'(8601600);
    localparam logic signed [X_W-1:0]   CV_LIMIT   = X_W'(12288);

    localparam logic signed [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(65536);
    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = '0;
    localparam logic [STRIDE_W-1:0]        STRIDE_RESET = STRIDE_W'(400);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN   = 2'd0,
        REG_OFFSET = 2'd1,
        REG_STRIDE = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic start;
        logic ch_zero;
    } win_req_t;

    typedef struct packed {
        logic done;
    } win_status_t;

endpackage

[design/asc_if.sv]
interface asc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [asc_pkg::CHAN_W-1:0]             channel;
    logic signed [asc_pkg::SAMPLE_W-1:0]    sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink (input valid, input channel, input sample_in, output ready);
endinterface

interface asc_out_if #(
    parameter int COUNT_W = 9
);
    logic                               valid;
    logic                               ready;
    logic signed [asc_pkg::CV_W-1:0]     scaled_out;
    logic signed [asc_pkg::X_W-1:0]      scaled_value;
    logic signed [asc_pkg::SAMPLE_W-1:0] through_out;
    logic signed [asc_pkg::X_W-1:0]      window_min;
    logic signed [asc_pkg::X_W-1:0]      window_max;
    logic [COUNT_W-1:0]                  window_count;

    modport source (
        output valid, output scaled_out, output scaled_value, output through_out,
        output window_min, output window_max, output window_count, input ready
    );
    modport sink (
        input valid, input scaled_out, input scaled_value, input through_out,
        input window_min, input window_max, input window_count, output ready
    );
endinterface

interface asc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [asc_pkg::CFG_INDEX_W-1:0]     index;
    logic [asc_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[design/asc_scale.sv]
module asc_scale (
    input  logic                                 clk,
    input  logic signed [asc_pkg::SAMPLE_W-1:0]  sample,
    input  logic signed [asc_pkg::GAIN_W-1:0]    gain,
    input  logic signed [asc_pkg::OFFSET_W-1:0]  offset,
    output logic signed [asc_pkg::X_W-1:0]       x
);

    logic signed [asc_pkg::PROD_W-1:0] prod_reg;
    logic signed [asc_pkg::SUM_W-1:0]  rounded;
    logic signed [asc_pkg::SUM_W-1:0]  sum;
    logic signed [asc_pkg::X_W-1:0]    x_next;
    logic signed [asc_pkg::X_W-1:0]    x_reg;

    // Adding one half before the arithmetic shift rounds to nearest, halves up.
    always_comb
    begin
        rounded = (asc_pkg::SUM_W'(prod_reg) + asc_pkg::ROUND_HALF) >>> asc_pkg::FRAC_W;
        sum     = rounded + asc_pkg::SUM_W'(offset);
        if (sum > asc_pkg::X_LIMIT)
        begin
            x_next = asc_pkg::X_W'(asc_pkg::X_LIMIT);
        end
        else if (sum < -asc_pkg::X_LIMIT)
        begin
            x_next = asc_pkg::X_W'(-asc_pkg::X_LIMIT);
        end
        else
        begin
            x_next = sum[asc_pkg::X_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= asc_pkg::PROD_W'(gain) * asc_pkg::PROD_W'(sample);
        x_reg    <= x_next;
    end

    assign x = x_reg;

endmodule

[design/asc_window.sv]
module asc_window #(
    parameter int HISTORY_DEPTH = 256,
    parameter int ADDR_W        = $clog2(HISTORY_DEPTH),
    parameter int COUNT_W       = $clog2(HISTORY_DEPTH + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  asc_pkg::win_req_t                    req,
    input  logic signed [asc_pkg::X_W-1:0]       x,
    input  logic [asc_pkg::STRIDE_W-1:0]         stride,
    output asc_pkg::win_status_t                 status,
    output logic signed [asc_pkg::X_W-1:0]       held_min,
    output logic signed [asc_pkg::X_W-1:0]       held_max,
    output logic [COUNT_W-1:0]                   fill_count
);

    typedef enum logic [2:0] {
        W_IDLE,
        W_PUSH,
        W_SCAN,
        W_DRAIN,
        W_DONE
    } win_state_t;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(HISTORY_DEPTH);
    localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(HISTORY_DEPTH - 1);

    logic signed [asc_pkg::X_W-1:0] mem [HISTORY_DEPTH];
    logic signed [asc_pkg::X_W-1:0] rd_data_reg;

    win_state_t                     state_reg;
    logic [asc_pkg::STRIDE_W-1:0]   decim_reg;
    logic [ADDR_W-1:0]              wr_pos_reg;
    logic [COUNT_W-1:0]             fill_reg;
    logic [ADDR_W-1:0]              rd_addr_reg;
    logic                           rd_valid_reg;
    logic                           first_reg;
    logic signed [asc_pkg::X_W-1:0] min_reg;
    logic signed [asc_pkg::X_W-1:0] max_reg;

    logic [asc_pkg::STRIDE_W:0]     decim_next;
    logic [asc_pkg::STRIDE_W:0]     stride_eff;
    logic                           last_addr;

    always_comb
    begin
        decim_next = {1'b0, decim_reg} + 1'b1;
        stride_eff = (stride == '0) ? (asc_pkg::STRIDE_W + 1)'(1) : {1'b0, stride};
        last_addr  = (COUNT_W'(rd_addr_reg) == fill_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == W_PUSH)
        begin
            mem[wr_pos_reg] <= x;
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= W_IDLE;
            decim_reg    <= '0;
            wr_pos_reg   <= '0;
            fill_reg     <= '0;
            rd_addr_reg  <= '0;
            rd_valid_reg <= 1'b0;
            first_reg    <= 1'b0;
            min_reg      <= '0;
            max_reg      <= '0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == W_SCAN);

            // The single compare unit folds one ring entry into the extremes per cycle.
            if (rd_valid_reg)
            begin
                first_reg <= 1'b0;
                if (first_reg || rd_data_reg < min_reg)
                begin
                    min_reg <= rd_data_reg;
                end
                if (first_reg || rd_data_reg > max_reg)
                begin
                    max_reg <= rd_data_reg;
                end
            end

            case (state_reg)
                W_IDLE:
                begin
                    if (req.start)
                    begin
                        if (!req.ch_zero)
                        begin
                            state_reg <= W_DONE;
                        end
                        else if (decim_next >= stride_eff)
                        begin
                            decim_reg <= '0;
                            state_reg <= W_PUSH;
                        end
                        else
                        begin
                            decim_reg <= decim_next[asc_pkg::STRIDE_W-1:0];
                            state_reg <= W_DONE;
                        end
                    end
                end
                W_PUSH:
                begin
                    wr_pos_reg  <= (wr_pos_reg == LAST_ADDR) ? '0 : wr_pos_reg + 1'b1;
                    if (fill_reg != FULL_COUNT)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    rd_addr_reg <= '0;
                    first_reg   <= 1'b1;
                    state_reg   <= W_SCAN;
                end
                W_SCAN:
                begin
                    if (last_addr)
                    begin
                        state_reg <= W_DRAIN;
                    end
                    else
                    begin
                        rd_addr_reg <= rd_addr_reg + 1'b1;
                    end
                end
                W_DRAIN:
                begin
                    state_reg <= W_DONE;
                end
                W_DONE:
                begin
                    state_reg <= W_IDLE;
                end
                default:
                begin
                    state_reg <= W_IDLE;
                end
            endcase
        end
    end

    assign status.done = (state_reg == W_DONE);
    assign held_min    = min_reg;
    assign held_max    = max_reg;
    assign fill_count  = fill_reg;

endmodule

[design/affine_scaler_window_min_max_top.sv]
// Scales each sample word as gain*sample + offset (Q9.16 gain, 1/1024 V units) and returns
// the result clamped to +/-12 V, clamped to +/-8400 V, and the raw sample, with the minimum
// and maximum over a ring of decimated channel-0 results. A sample is taken only while
// the block is idle and occupies it until its result word is loaded into the output
// register: it steps through the multiply, add, window and wait states, and when it pushes
// to the history a single compare unit rescans every filled ring entry (up to HISTORY_DEPTH)
// through one memory read port. The next sample can be taken in the cycle after that load at
// the earliest. A new sample is accepted while the previous result word still waits in the
// output register. The ring needs no clearing after reset because only written entries
// are ever scanned.
module affine_scaler_window_min_max_top #(
    parameter int HISTORY_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    asc_in_if.sink     samples,
    asc_out_if.source  results,
    asc_cfg_if.sink    cfg
);

    localparam int COUNT_W = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [2:0] {
        T_IDLE,
        T_MUL,
        T_ADD,
        T_WIN,
        T_WAIT,
        T_OUT
    } top_state_t;

    top_state_t                              state_reg;
    logic [asc_pkg::CHAN_W-1:0]              channel_reg;
    logic signed [asc_pkg::SAMPLE_W-1:0]     sample_reg;
    logic signed [asc_pkg::GAIN_W-1:0]       gain_reg;
    logic signed [asc_pkg::OFFSET_W-1:0]     offset_reg;
    logic [asc_pkg::STRIDE_W-1:0]            stride_reg;

    logic                                    out_valid_reg;
    logic signed [asc_pkg::CV_W-1:0]         scaled_out_reg;
    logic signed [asc_pkg::X_W-1:0]          scaled_value_reg;
    logic signed [asc_pkg::SAMPLE_W-1:0]     through_out_reg;
    logic signed [asc_pkg::X_W-1:0]          window_min_reg;
    logic signed [asc_pkg::X_W-1:0]          window_max_reg;
    logic [COUNT_W-1:0]                      window_count_reg;

    logic signed [asc_pkg::X_W-1:0]          x;
    logic signed [asc_pkg::CV_W-1:0]         cv;
    logic signed [asc_pkg::X_W-1:0]          held_min;
    logic signed [asc_pkg::X_W-1:0]          held_max;
    logic [COUNT_W-1:0]                      fill_count;
    asc_pkg::win_req_t                       win_req;
    asc_pkg::win_status_t                    win_status;
    logic                                    in_fire;
    logic                                    out_load;

    asc_scale u_scale (
        .clk    (clk),
        .sample (sample_reg),
        .gain   (gain_reg),
        .offset (offset_reg),
        .x      (x)
    );

    asc_window #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .COUNT_W       (COUNT_W)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (win_req),
        .x          (x),
        .stride     (stride_reg),
        .status     (win_status),
        .held_min   (held_min),
        .held_max   (held_max),
        .fill_count (fill_count)
    );

    always_comb
    begin
        win_req.start   = (state_reg == T_WIN);
        win_req.ch_zero = (channel_reg == '0);
        in_fire         = samples.valid && samples.ready;
        out_load        = (state_reg == T_OUT) && (!out_valid_reg || results.ready);
        if (x > asc_pkg::CV_LIMIT)
        begin
            cv = asc_pkg::CV_W'(asc_pkg::CV_LIMIT);
        end
        else if (x < -asc_pkg::CV_LIMIT)
        begin
            cv = asc_pkg::CV_W'(-asc_pkg::CV_LIMIT);
        end
        else
        begin
            cv = x[asc_pkg::CV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= asc_pkg::GAIN_RESET;
            offset_reg <= asc_pkg::OFFSET_RESET;
            stride_reg <= asc_pkg::STRIDE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                asc_pkg::REG_GAIN:
                begin
                    gain_reg <= cfg.data[asc_pkg::GAIN_W-1:0];
                end
                asc_pkg::REG_OFFSET:
                begin
                    offset_reg <= cfg.data[asc_pkg::OFFSET_W-1:0];
                end
                asc_pkg::REG_STRIDE:
                begin
                    stride_reg <= cfg.data[asc_pkg::STRIDE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            channel_reg <= samples.channel;
            sample_reg  <= samples.sample_in;
        end
        if (out_load)
        begin
            scaled_out_reg   <= cv;
            scaled_value_reg <= x;
            through_out_reg  <= sample_reg;
            window_min_reg   <= held_min;
            window_max_reg   <= held_max;
            window_count_reg <= fill_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                T_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= T_MUL;
                    end
                end
                T_MUL:
                begin
                    state_reg <= T_ADD;
                end
                T_ADD:
                begin
                    state_reg <= T_WIN;
                end
                T_WIN:
                begin
                    state_reg <= T_WAIT;
                end
                T_WAIT:
                begin
                    if (win_status.done)
                    begin
                        state_reg <= T_OUT;
                    end
                end
                T_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign samples.ready        = (state_reg == T_IDLE);
    assign cfg.ready            = 1'b1;
    assign results.valid        = out_valid_reg;
    assign results.scaled_out   = scaled_out_reg;
    assign results.scaled_value = scaled_value_reg;
    assign results.through_out  = through_out_reg;
    assign results.window_min   = window_min_reg;
    assign results.window_max   = window_max_reg;
    assign results.window_count = window_count_reg;

endmodule

[sim/tb_top.sv]
module tb_top;

    localparam int RING_DEPTH  = 256;
    localparam int COUNT_W     = $clog2(RING_DEPTH + 1);
    localparam longint X_MAX   = 8601600;
    localparam longint CV_MAX  = 12288;
    localparam int HOLD_CYCLES = 2000;
    localparam int TAIL_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    localparam logic [asc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [asc_pkg::CHAN_W-1:0]          channel;
        logic signed [asc_pkg::SAMPLE_W-1:0] sample;
    } sample_item_t;

    typedef struct packed {
        logic signed [asc_pkg::CV_W-1:0]     scaled_out;
        logic signed [asc_pkg::X_W-1:0]      scaled_value;
        logic signed [asc_pkg::SAMPLE_W-1:0] through_out;
        logic signed [asc_pkg::X_W-1:0]      window_min;
        logic signed [asc_pkg::X_W-1:0]      window_max;
        logic [COUNT_W-1:0]                  window_count;
    } scaler_word_t;

    logic clk = 1'b0;
    logic rst_n;

    asc_in_if                      samples_if ();
    asc_out_if #(.COUNT_W(COUNT_W)) results_if ();
    asc_cfg_if                     cfg_if ();

    affine_scaler_window_min_max_top #(
        .HISTORY_DEPTH(RING_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(samples_if),
        .results(results_if),
        .cfg    (cfg_if)
    );

    always #5 clk = ~clk;

    // Shadow copy of the block: registers, history ring and decimation.
    longint                       cur_gain   = 65536;
    longint                       cur_offset = 0;
    logic [asc_pkg::STRIDE_W-1:0] cur_stride = 16'd400;
    longint                       ring_hist [RING_DEPTH];
    int                           ring_wr_pos = 0;
    int                           ring_fill   = 0;
    int                           decim_cnt   = 0;
    longint                       held_lo     = 0;
    longint                       held_hi     = 0;

    sample_item_t pending_samples [$];
    scaler_word_t expected_words [$];

    int  send_idle_pct = 0;
    int  rx_stall_pct  = 0;
    bit  hold_go       = 1'b0;
    bit  rx_hold       = 1'b0;
    logic in_fire;

    int samples_sent  = 0;
    int words_checked = 0;
    int mismatch_cnt  = 0;
    int push_cnt      = 0;
    int peak_fill     = 0;

    function automatic void apply_reg(input logic [asc_pkg::CFG_INDEX_W-1:0] idx,
                                      input logic [asc_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            asc_pkg::REG_GAIN:
                cur_gain   = longint'($signed(value[asc_pkg::GAIN_W-1:0]));
            asc_pkg::REG_OFFSET:
                cur_offset = longint'($signed(value[asc_pkg::OFFSET_W-1:0]));
            asc_pkg::REG_STRIDE:
                cur_stride = value[asc_pkg::STRIDE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic scaler_word_t predict_word(
        input logic [asc_pkg::CHAN_W-1:0] ch,
        input logic signed [asc_pkg::SAMPLE_W-1:0] s);
        scaler_word_t w;
        longint x;
        longint lo;
        longint hi;
        longint cv;
        int stride;
        x = (cur_gain * longint'(s) + 32768) >>> 16;
        x = x + cur_offset;
        if (x > X_MAX)
            x = X_MAX;
        else if (x < -X_MAX)
            x = -X_MAX;
        if (ch == 0)
        begin
            stride = (cur_stride == 0) ? 1 : int'(cur_stride);
            decim_cnt = (decim_cnt + 1) & 'h1FFFF;
            if (decim_cnt >= stride)
            begin
                decim_cnt = 0;
                ring_hist[ring_wr_pos] = x;
                ring_wr_pos = (ring_wr_pos + 1) % RING_DEPTH;
                if (ring_fill < RING_DEPTH)
                    ring_fill++;
                lo = ring_hist[0];
                hi = ring_hist[0];
                for (int i = 1; i < ring_fill; i++)
                begin
                    if (ring_hist[i] < lo)
                        lo = ring_hist[i];
                    if (ring_hist[i] > hi)
                        hi = ring_hist[i];
                end
                held_lo = lo;
                held_hi = hi;
                push_cnt++;
                if (ring_fill > peak_fill)
                    peak_fill = ring_fill;
            end
        end
        cv = (x > CV_MAX) ? CV_MAX : ((x < -CV_MAX) ? -CV_MAX : x);
        w.scaled_out   = asc_pkg::CV_W'(cv);
        w.scaled_value = asc_pkg::X_W'(x);
        w.through_out  = s;
        w.window_min   = asc_pkg::X_W'(held_lo);
        w.window_max   = asc_pkg::X_W'(held_hi);
        w.window_count = COUNT_W'(ring_fill);
        return w;
    endfunction

    function automatic logic signed [asc_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(19))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return asc_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= samples_if.valid && samples_if.ready;
            if (samples_if.valid && samples_if.ready)
            begin
                expected_words.push_back(predict_word(samples_if.channel,
                                                      samples_if.sample_in));
                samples_sent++;
            end
            if (cfg_if.valid && cfg_if.ready)
                apply_reg(cfg_if.index, cfg_if.data);
        end
    end

    always @(negedge clk)
    begin : sample_driver
        sample_item_t nxt;
        if (!rst_n)
        begin
            samples_if.valid <= 1'b0;
        end
        else if (!samples_if.valid || in_fire)
        begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_samples.pop_front();
                samples_if.valid     <= 1'b1;
                samples_if.channel   <= nxt.channel;
                samples_if.sample_in <= nxt.sample;
            end
            else
            begin
                samples_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        results_if.ready <= rst_n && !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin : word_monitor
        scaler_word_t got;
        scaler_word_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            got.scaled_out   = results_if.scaled_out;
            got.scaled_value = results_if.scaled_value;
            got.through_out  = results_if.through_out;
            got.window_min   = results_if.window_min;
            got.window_max   = results_if.window_max;
            got.window_count = results_if.window_count;
            words_checked++;
            if (expected_words.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("%0t: result word with nothing expected: out=%0d x=%0d thru=%0d",
                             $realtime, got.scaled_out, got.scaled_value, got.through_out);
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.scaled_out !== want.scaled_out
                    || got.scaled_value !== want.scaled_value
                    || got.through_out !== want.through_out
                    || got.window_min !== want.window_min
                    || got.window_max !== want.window_max
                    || got.window_count !== want.window_count)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                    begin
                        $display("%0t: word %0d exp out=%0d x=%0d thru=%0d min=%0d max=%0d n=%0d",
                                 $realtime, words_checked, want.scaled_out, want.scaled_value,
                                 want.through_out, want.window_min, want.window_max,
                                 want.window_count);
                        $display("%0t: word %0d got out=%0d x=%0d thru=%0d min=%0d max=%0d n=%0d",
                                 $realtime, words_checked, got.scaled_out, got.scaled_value,
                                 got.through_out, got.window_min, got.window_max,
                                 got.window_count);
                    end
                end
            end
        end
    end

    initial
    begin : receiver_hold
        wait (hold_go);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic write_reg(input logic [asc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [asc_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk);
        while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_config(input int g, input int o, input int st);
        write_reg(asc_pkg::REG_GAIN, asc_pkg::CFG_DATA_W'(g));
        write_reg(asc_pkg::REG_OFFSET, asc_pkg::CFG_DATA_W'(o));
        write_reg(asc_pkg::REG_STRIDE, asc_pkg::CFG_DATA_W'(st));
    endtask

    task automatic add_item(input int ch, input int s);
        pending_samples.push_back('{channel: asc_pkg::CHAN_W'(ch),
                                    sample: asc_pkg::SAMPLE_W'(s)});
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (pending_samples.size() != 0 || samples_if.valid
               || expected_words.size() != 0);
    endtask

    // Mostly frames that start on channel 0; the rest are lone words and
    // frames that begin on some other channel.
    task automatic queue_random(input int n, input int max_len, input int s_pct,
                                input int r_pct);
        int made;
        int kind;
        int first;
        int len;
        made = 0;
        send_idle_pct = s_pct;
        rx_stall_pct  = r_pct;
        while (made < n)
        begin
            kind = $urandom_range(99);
            if (kind < 80)
            begin
                first = 0;
                len   = $urandom_range(1, max_len);
            end
            else if (kind < 90)
            begin
                first = $urandom_range(15);
                len   = 1;
            end
            else
            begin
                first = $urandom_range(1, 15);
                len   = $urandom_range(1, 16 - first);
            end
            for (int c = first; c < first + len && made < n; c++)
            begin
                pending_samples.push_back('{channel: asc_pkg::CHAN_W'(c),
                                            sample: pick_sample()});
                made++;
            end
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n                = 1'b0;
        samples_if.valid     = 1'b0;
        samples_if.channel   = '0;
        samples_if.sample_in = '0;
        results_if.ready     = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: no push yet, so the window reads empty.
        add_item(0, 0);
        add_item(15, 32767);
        add_item(0, -32768);
        add_item(7, -1);
        wait_idle();

        // Largest legal gain and offset, with a zero stride acting as one.
        set_config(13107200, 2048000, 0);
        add_item(0, 32767);
        add_item(0, -32768);
        add_item(15, 1);
        add_item(0, 1);
        wait_idle();

        // Gain and offset beyond their ranges saturate the scaled value.
        set_config(-16777216, -2097152, 1);
        add_item(0, 32767);
        add_item(3, -32768);
        add_item(0, -32768);
        wait_idle();

        // A write to an unused index must change nothing.
        write_reg(REG_UNUSED, asc_pkg::CFG_DATA_W'($urandom()));

        // Half gain shows rounding of exact halves toward plus infinity.
        set_config(32768, 0, 1);
        add_item(1, 1);
        add_item(2, -1);
        add_item(0, 3);
        add_item(4, -3);
        wait_idle();

        // Lowering the stride below the running count pushes on the next word.
        set_config(16777215, 2097151, 5);
        add_item(0, 100);
        add_item(0, -100);
        add_item(0, 32767);
        wait_idle();
        write_reg(asc_pkg::REG_STRIDE, asc_pkg::CFG_DATA_W'(2));
        add_item(0, -200);
        add_item(8, 5);
        wait_idle();

        set_config(65536, 0, 1);
        queue_random(300, 2, 0, 0);

        set_config(int'($urandom_range(26214400)) - 13107200,
                   int'($urandom_range(4096000)) - 2048000, 2);
        queue_random(300, 16, 78, 0);

        set_config(-196608, int'($urandom_range(4096000)) - 2048000, 3);
        queue_random(300, 16, 0, 78);

        set_config(13107200, -2048000, 1);
        hold_go = 1'b1;
        queue_random(300, 4, 6, 6);

        set_config(-13107200, 2048000, 65535);
        queue_random(150, 16, 0, 0);

        write_reg(asc_pkg::REG_GAIN, asc_pkg::CFG_DATA_W'($urandom()));
        write_reg(asc_pkg::REG_OFFSET, asc_pkg::CFG_DATA_W'($urandom()));
        write_reg(asc_pkg::REG_STRIDE, asc_pkg::CFG_DATA_W'(0));
        queue_random(300, 3, 78, 0);

        write_reg(asc_pkg::REG_GAIN,
                  asc_pkg::CFG_DATA_W'(int'($urandom_range(26214400)) - 13107200));
        write_reg(asc_pkg::REG_OFFSET, {3'($urandom()),
                                        22'(int'($urandom_range(4096000)) - 2048000)});
        write_reg(asc_pkg::REG_STRIDE, asc_pkg::CFG_DATA_W'($urandom_range(1, 4)));
        queue_random(250, 16, 0, 78);

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d sample words and %0d result words, %0d history pushes,",
                 samples_sent, words_checked, push_cnt);
        $display("peak ring fill %0d of %0d, register extremes and a %0d-cycle output hold.",
                 peak_fill, RING_DEPTH, HOLD_CYCLES);
        if (mismatch_cnt == 0 && expected_words.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("Mismatches: %0d, expected words never seen: %0d",
                     mismatch_cnt, expected_words.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
design/asc_pkg.sv
design/asc_if.sv
design/asc_scale.sv
design/asc_window.sv
design/affine_scaler_window_min_max_top.sv
sim/tb_top.sv
